// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the scrambler rtl
// no dependencies; include with the bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain invariant, checked on every clock edge out of reset
`define KBS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// same-cycle implication
`define KBS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/kbs_pkg.sv =====
// types, constants and byte functions of the keyed byte scrambler
// no dependencies; used by the top level, kbs_mod_pipe, kbs_key_store and kbs_mix
`timescale 1ns / 1ps
`default_nettype none

package kbs_pkg;

  typedef enum logic [1:0] {
    OP_DECRYPT   = 2'd0,
    OP_ENCRYPT   = 2'd1,
    OP_LOAD_PW   = 2'd2,
    OP_LOAD_HASH = 2'd3
  } op_e;

  localparam logic [1:0] CFG_ENABLED   = 2'd0;
  localparam logic [1:0] CFG_PW_LEN    = 2'd1;
  localparam logic [1:0] CFG_HDR_BYTES = 2'd2;

  localparam int HASH_BYTES     = 32;
  localparam int HASH_AW        = 5;
  localparam int POS_W          = 32;
  localparam int MOD_STAGES     = 4;
  localparam int BITS_PER_STAGE = POS_W / MOD_STAGES;

  typedef struct packed {
    logic        enabled;
    logic [6:0]  pw_len;
    logic [15:0] hdr_bytes;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [31:0] pos;
    logic [7:0]  value;
    logic        last;
    logic        bypass;
    logic [6:0]  rem;
  } mod_item_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] value;
    logic       last;
    logic       bypass;
    logic [7:0] pw;
    logic [7:0] hash;
  } key_item_t;

  // restoring remainder over one slice of the offset, msb first
  function automatic logic [6:0] mod_step(input logic [6:0] rem,
                                          input logic [BITS_PER_STAGE-1:0] bits,
                                          input logic [6:0] len);
    logic [7:0] t;
    logic [6:0] r;
    r = rem;
    for (int i = BITS_PER_STAGE - 1; i >= 0; i--) begin
      t = {r, bits[i]};
      if (t >= {1'b0, len}) begin
        t = t - {1'b0, len};
      end
      r = t[6:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] rotl8(input logic [7:0] x, input logic [2:0] n);
    logic [15:0] d;
    d = {x, x} << n;
    return d[15:8];
  endfunction

  function automatic logic [7:0] rotr8(input logic [7:0] x, input logic [2:0] n);
    logic [15:0] d;
    d = {x, x} >> n;
    return d[7:0];
  endfunction

  function automatic logic [7:0] encrypt8(input logic [7:0] x, input logic [7:0] pw,
                                          input logic [7:0] h);
    logic [7:0] y;
    y = rotl8(x ^ h, pw[2:0]) ^ pw;
    if (pw[0]) begin
      y = rotl8(y, 3'd2);
    end
    if (h[0]) begin
      y = ~y;
    end
    return y;
  endfunction

  function automatic logic [7:0] decrypt8(input logic [7:0] x, input logic [7:0] pw,
                                          input logic [7:0] h);
    logic [7:0] y;
    y = h[0] ? ~x : x;
    if (pw[0]) begin
      y = rotr8(y, 3'd2);
    end
    y = rotr8(y ^ pw, pw[2:0]) ^ h;
    return y;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/kbs_in_if.sv =====
// input channel of the scrambler: valid, ready and one command item
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface kbs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [31:0] position;
  logic [7:0]  value;
  logic        last;

  modport source (output valid, operation, position, value, last, input ready);
  modport sink   (input valid, operation, position, value, last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/kbs_out_if.sv =====
// output channel of the scrambler: valid, ready and one result byte
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

interface kbs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;
  logic       result_last;

  modport source (output valid, result_byte, result_last, input ready);
  modport sink   (input valid, result_byte, result_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/keyed_byte_scrambler.sv =====
// keyed byte scrambler top level: config registers and the stage chain
// depends on kbs_pkg, kbs_in_if, kbs_out_if, kbs_mod_pipe, kbs_key_store,
// kbs_mix and assert_macros.svh
//
// usage
//   in_i carries commands: decrypt or encrypt a byte at a file offset, or
//   load a password or hash byte at a store index. a transfer happens when
//   valid and ready are both high. data commands give one result on out_o,
//   loads give none. config is written through cfg_we_i / cfg_idx_i /
//   cfg_wdata_i while the block is idle.
//   an input transfer reaches result valid through six registers: four
//   remainder stages, each doing eight restoring steps of offset mod
//   password length, one key store read stage, one transform and output
//   register. one item per cycle is taken unless out_o stalls, as each stage's
//   step is combinational; the password memory port gives one read per cycle.
//   every stage has its own valid bit, so bubbles close up when out_o
//   stalls and input is still taken until the chain is full.
//   reset empties the chain, clears the password valid bits and the hash
//   registers at once (no clearing pass) and loads enabled 0, password
//   length 1 and header bytes 0.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module keyed_byte_scrambler #(
  parameter int MAX_PASSWORD_BYTES = 128
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  kbs_in_if.sink           in_i,
  kbs_out_if.source        out_o
);

  logic        enabled_q;
  logic [6:0]  pw_len_q;
  logic [15:0] hdr_bytes_q;

  kbs_pkg::cfg_t      cfg;
  logic               mod_valid;
  logic               mod_ready;
  kbs_pkg::mod_item_t mod_item;
  logic               ks_valid;
  logic               ks_ready;
  kbs_pkg::key_item_t ks_item;
  logic               ks_is_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q   <= 1'b0;
      pw_len_q    <= 7'd1;
      hdr_bytes_q <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kbs_pkg::CFG_ENABLED:   enabled_q   <= cfg_wdata_i[0];
        kbs_pkg::CFG_PW_LEN:    pw_len_q    <= cfg_wdata_i[6:0];
        kbs_pkg::CFG_HDR_BYTES: hdr_bytes_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // zero length counts as one
  always_comb begin
    cfg.enabled   = enabled_q;
    cfg.pw_len    = (pw_len_q == 7'd0) ? 7'd1 : pw_len_q;
    cfg.hdr_bytes = hdr_bytes_q;
  end

  kbs_mod_pipe u_mod_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_i        (in_i),
    .out_valid_o (mod_valid),
    .out_ready_i (mod_ready),
    .out_item_o  (mod_item)
  );

  kbs_key_store #(
    .MAX_PASSWORD_BYTES (MAX_PASSWORD_BYTES)
  ) u_key_store (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mod_valid),
    .in_ready_o  (mod_ready),
    .in_item_i   (mod_item),
    .out_valid_o (ks_valid),
    .out_ready_i (ks_ready),
    .out_item_o  (ks_item)
  );

  kbs_mix u_mix (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (ks_valid),
    .in_ready_o (ks_ready),
    .in_item_i  (ks_item),
    .out_o      (out_o)
  );

  assign ks_is_data = (ks_item.op == kbs_pkg::OP_DECRYPT) ||
                      (ks_item.op == kbs_pkg::OP_ENCRYPT);

  `KBS_ASSERT(a_len_nonzero, clk_i, rst_ni, cfg.pw_len != 7'd0, "password length is zero")
  `KBS_ASSERT_IMPLIES(a_key_data_only, clk_i, rst_ni, ks_valid, ks_is_data, "load passed key store")

endmodule

`default_nettype wire

// ===== rtl/core/kbs_mod_pipe.sv =====
// offset modulo password length, one byte of the offset per stage
// depends on kbs_pkg and kbs_in_if
`timescale 1ns / 1ps
`default_nettype none

module kbs_mod_pipe (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire kbs_pkg::cfg_t     cfg_i,
  kbs_in_if.sink                 in_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output kbs_pkg::mod_item_t     out_item_o
);

  localparam int NS = kbs_pkg::MOD_STAGES;
  localparam int BW = kbs_pkg::BITS_PER_STAGE;

  logic [NS-1:0]      v_q;
  kbs_pkg::mod_item_t item_q [NS];
  logic [NS:0]        rdy;

  assign rdy[NS]  = out_ready_i;
  assign in_i.ready = rdy[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int HI = kbs_pkg::POS_W - 1 - BW * k;
    logic               v_in;
    kbs_pkg::mod_item_t it_in;
    kbs_pkg::mod_item_t it_d;

    assign rdy[k] = !v_q[k] || rdy[k+1];

    if (k == 0) begin : g_first
      always_comb begin
        v_in         = in_i.valid;
        it_in.op     = kbs_pkg::op_e'(in_i.operation);
        it_in.pos    = in_i.position;
        it_in.value  = in_i.value;
        it_in.last   = in_i.last;
        it_in.bypass = !cfg_i.enabled || (in_i.position < {16'd0, cfg_i.hdr_bytes});
        it_in.rem    = '0;
      end
    end else begin : g_next
      always_comb begin
        v_in  = v_q[k-1];
        it_in = item_q[k-1];
      end
    end

    always_comb begin
      it_d     = it_in;
      it_d.rem = kbs_pkg::mod_step(it_in.rem, it_in.pos[HI -: BW], cfg_i.pw_len);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[k] && v_in) begin
        item_q[k] <= it_d;
      end
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign out_item_o  = item_q[NS-1];

endmodule

`default_nettype wire

// ===== rtl/core/kbs_key_store.sv =====
// password memory with valid bits and hash registers; loads end here
// depends on kbs_pkg
`timescale 1ns / 1ps
`default_nettype none

module kbs_key_store #(
  parameter int MAX_PASSWORD_BYTES = 128
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire kbs_pkg::mod_item_t in_item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output kbs_pkg::key_item_t     out_item_o
);

  localparam int PW_AW = $clog2(MAX_PASSWORD_BYTES);

  logic [7:0]                    pw_mem [MAX_PASSWORD_BYTES];
  logic [MAX_PASSWORD_BYTES-1:0] pw_vld_q;
  logic [7:0]                    hash_q [kbs_pkg::HASH_BYTES];

  logic             v_q;
  logic [7:0]       pw_rd_q;
  logic             pw_ok_q;
  logic [7:0]       hash_rd_q;
  kbs_pkg::op_e     op_q;
  logic [7:0]       value_q;
  logic             last_q;
  logic             bypass_q;

  logic             xfer;
  logic             is_data;
  logic             pw_wr;
  logic             hash_wr;
  logic             rd;
  logic [7:0]       pidx;
  logic             pw_in_range;
  logic [PW_AW-1:0] ra;
  logic [PW_AW-1:0] wa;
  logic [kbs_pkg::HASH_AW-1:0] hidx;

  assign in_ready_o  = !v_q || out_ready_i;
  assign xfer        = in_valid_i && in_ready_o;
  assign is_data     = (in_item_i.op == kbs_pkg::OP_DECRYPT) ||
                       (in_item_i.op == kbs_pkg::OP_ENCRYPT);
  assign pw_wr       = xfer && (in_item_i.op == kbs_pkg::OP_LOAD_PW) &&
                       (in_item_i.pos < 32'(MAX_PASSWORD_BYTES));
  assign hash_wr     = xfer && (in_item_i.op == kbs_pkg::OP_LOAD_HASH) &&
                       (in_item_i.pos[31:kbs_pkg::HASH_AW] == '0);
  assign rd          = xfer && is_data;
  assign pidx        = {1'b0, in_item_i.rem};
  assign pw_in_range = {24'd0, pidx} < 32'(MAX_PASSWORD_BYTES);
  assign ra          = pidx[PW_AW-1:0];
  assign wa          = in_item_i.pos[PW_AW-1:0];
  assign hidx        = in_item_i.pos[kbs_pkg::HASH_AW-1:0];

  always_ff @(posedge clk_i) begin
    if (pw_wr) begin
      pw_mem[wa] <= in_item_i.value;
    end
    if (rd) begin
      pw_rd_q <= pw_mem[ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_vld_q <= '0;
      for (int i = 0; i < kbs_pkg::HASH_BYTES; i++) begin
        hash_q[i] <= '0;
      end
    end else begin
      if (pw_wr) begin
        pw_vld_q[wa] <= 1'b1;
      end
      if (hash_wr) begin
        hash_q[hidx] <= in_item_i.value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i && is_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd) begin
      pw_ok_q   <= pw_in_range && pw_vld_q[ra];
      hash_rd_q <= hash_q[hidx];
      op_q      <= in_item_i.op;
      value_q   <= in_item_i.value;
      last_q    <= in_item_i.last;
      bypass_q  <= in_item_i.bypass;
    end
  end

  always_comb begin
    out_item_o.op     = op_q;
    out_item_o.value  = value_q;
    out_item_o.last   = last_q;
    out_item_o.bypass = bypass_q;
    out_item_o.pw     = pw_ok_q ? pw_rd_q : 8'd0;
    out_item_o.hash   = hash_rd_q;
  end

  assign out_valid_o = v_q;

endmodule

`default_nettype wire

// ===== rtl/core/kbs_mix.sv =====
// byte transform and output register
// depends on kbs_pkg and kbs_out_if
`timescale 1ns / 1ps
`default_nettype none

module kbs_mix (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire kbs_pkg::key_item_t in_item_i,
  kbs_out_if.source              out_o
);

  logic       v_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic [7:0] byte_d;

  assign in_ready_o = !v_q || out_o.ready;

  always_comb begin
    if (in_item_i.bypass) begin
      byte_d = in_item_i.value;
    end else if (in_item_i.op == kbs_pkg::OP_ENCRYPT) begin
      byte_d = kbs_pkg::encrypt8(in_item_i.value, in_item_i.pw, in_item_i.hash);
    end else begin
      byte_d = kbs_pkg::decrypt8(in_item_i.value, in_item_i.pw, in_item_i.hash);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (in_ready_o) begin
      v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= byte_d;
      last_q <= in_item_i.last;
    end
  end

  assign out_o.valid       = v_q;
  assign out_o.result_byte = byte_q;
  assign out_o.result_last = last_q;

endmodule

`default_nettype wire
